@@ sv/plct_pkg.sv @@
package plct_pkg;

    localparam int unsigned VOLT_W  = 12;
    localparam int unsigned LEVEL_W = 14;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 14'd10000;
    localparam logic [VOLT_W-1:0]  VOLT_MAX_MV = 12'd3300;

    typedef enum logic [1:0] {
        OP_CONVERT = 2'd0,
        OP_ADD     = 2'd1,
        OP_RESET   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REPLACED = 3'd1,
        ST_LEVEL    = 3'd2,
        ST_FULL     = 3'd3,
        ST_VOLT     = 3'd4,
        ST_NO_SLOT  = 3'd5,
        ST_LVL_ORD  = 3'd6,
        ST_VOLT_ORD = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]         op;
        logic [VOLT_W-1:0]  voltage_mv;
        logic [LEVEL_W-1:0] level_in;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_out;
        logic               updated;
        logic [2:0]         status;
        logic [3:0]         points_used;
    } t_out;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] num;
        logic [VOLT_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic [LEVEL_W+VOLT_W-1:0]  quot;
        logic                       rem_nz;
    } t_div_rsp;

endpackage

@@ sv/plct_div.sv @@
module plct_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plct_pkg::t_div_req i_req,
    input  logic [plct_pkg::VOLT_W-1:0] i_off,
    output plct_pkg::t_div_rsp o_rsp
);
    import plct_pkg::*;

    localparam int unsigned PW = LEVEL_W + VOLT_W;
    localparam int unsigned CW = $clog2(PW + 1);

    logic [PW-1:0]     r_quo, n_quo;
    logic [VOLT_W:0]   r_rem, n_rem;
    logic [VOLT_W-1:0] r_den;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done;
    logic [PW-1:0]     r_prod;
    logic [VOLT_W:0]   w_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_sh   = {r_rem[VOLT_W-1:0], r_quo[PW-1]};
        if (r_busy) begin
            n_quo = {r_quo[PW-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem    = w_sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_req.num) * PW'(i_off);
        r_den  <= i_req.den;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !n_busy;
            if (i_req.start) begin
                r_busy <= 1'b0;
                r_cnt  <= CW'(PW);
            end else if (r_cnt == CW'(PW) && !r_busy) begin
                r_busy <= 1'b1;
                r_quo  <= r_prod;
                r_rem  <= '0;
            end else begin
                r_busy <= n_busy;
                r_cnt  <= n_cnt;
                r_quo  <= n_quo;
                r_rem  <= n_rem;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quo;
    assign o_rsp.rem_nz = (r_rem != '0);

endmodule

@@ sv/piecewise_linear_calibration_table.sv @@
// Convert reads one table entry per cycle, pausing while the bit-serial divider interpolates;
// add walks the table up to four times (match, slot search, shift, order check); reset
// clears the table in one pass.
// One item at a time: busy stays high from acceptance until the result strobe.
// Synchronous reset runs a pass over the table memory, with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module piecewise_linear_calibration_table #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  plct_pkg::t_in  i_item,
    output logic           o_valid,
    output plct_pkg::t_out o_result
);
    import plct_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_CONV   = 11'b00000000100,
        S_DIV    = 11'b00000001000,
        S_MATCH  = 11'b00000010000,
        S_FIND   = 11'b00000100000,
        S_SHIFT  = 11'b00001000000,
        S_WRITE  = 11'b00010000000,
        S_ORDER  = 11'b00100000000,
        S_DONE   = 11'b01000000000,
        S_DWAIT  = 11'b10000000000
    } t_state;

    logic [VOLT_W+LEVEL_W-1:0] r_mem [TABLE_SLOTS];
    logic [VOLT_W+LEVEL_W-1:0] r_rd;
    logic [AW-1:0]             w_ra, w_wa;
    logic                      w_we;
    logic [VOLT_W+LEVEL_W-1:0] w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    t_state              r_st;
    t_in                 r_in;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_pos;
    logic                r_rdv;
    logic [VOLT_W-1:0]   r_pv;
    logic [LEVEL_W-1:0]  r_pl;
    logic                r_have_prev;
    logic [LEVEL_W-1:0]  r_held;
    logic [2:0]          r_status;
    logic                r_upd;
    logic                r_ovalid;
    logic                r_desc;
    logic [VOLT_W-1:0]   r_den;
    logic [LEVEL_W-1:0]  r_num;
    logic [VOLT_W-1:0]   r_off;
    logic [LEVEL_W-1:0]  r_lo;
    logic                r_divgo;
    t_div_req            w_req;
    t_div_rsp            w_rsp;

    logic [VOLT_W-1:0]   w_cv;
    logic [LEVEL_W-1:0]  w_cl;
    assign w_cv = r_rd[VOLT_W+LEVEL_W-1:LEVEL_W];
    assign w_cl = r_rd[LEVEL_W-1:0];

    assign w_req.start = r_divgo;
    assign w_req.num   = r_num;
    assign w_req.den   = r_den;

    plct_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_off  (r_off),
        .o_rsp  (w_rsp)
    );

    // Address and write logic.
    always_comb begin
        w_ra = r_k[AW-1:0];
        w_we = 1'b0;
        w_wa = r_k[AW-1:0];
        w_wd = '0;
        unique case (r_st)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wd = (r_k == CW'(1)) ? {VOLT_MAX_MV, LEVEL_MAX} : '0;
            end
            S_SHIFT: begin
                w_ra = r_k[AW-1:0] - AW'(1);
                w_we = r_rdv && r_k > r_pos;
                w_wa = r_k[AW-1:0];
                w_wd = r_rd;
            end
            S_WRITE: begin
                w_we = 1'b1;
                w_wa = r_pos[AW-1:0];
                w_wd = {r_in.voltage_mv, r_in.level_in};
            end
            default: ;
        endcase
    end

    logic [LEVEL_W+VOLT_W-1:0] w_q;
    logic [LEVEL_W+VOLT_W:0]   w_drop;
    assign w_q    = w_rsp.quot;
    assign w_drop = {1'b0, w_q}
                  + (LEVEL_W+VOLT_W+1)'((r_desc && w_rsp.rem_nz) ? 1'b1 : 1'b0);

    always_ff @(posedge i_clk) begin
        r_ovalid <= 1'b0;
        r_divgo  <= 1'b0;
        if (!i_rst_n) begin
            r_st        <= S_CLEAR;
            r_k         <= '0;
            r_cnt       <= CW'(2);
            r_held      <= '0;
            r_rdv       <= 1'b0;
            r_have_prev <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            unique case (r_st)
                S_CLEAR: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == CW'(TABLE_SLOTS - 1)) begin
                        r_st <= r_in.op == OP_RESET && r_have_prev ? S_DONE : S_IDLE;
                        r_cnt <= CW'(2);
                    end
                end
                S_IDLE: begin
                    r_have_prev <= 1'b0;
                    r_status    <= ST_OK;
                    r_upd       <= 1'b0;
                    r_rdv       <= 1'b0;
                    r_k         <= '0;
                    if (start) begin
                        r_in <= i_item;
                        unique case (t_op'(i_item.op))
                            OP_CONVERT: r_st <= S_CONV;
                            OP_ADD: begin
                                if (i_item.level_in > LEVEL_MAX) begin
                                    r_status <= ST_LEVEL;
                                    r_st     <= S_DONE;
                                end else if (r_cnt >= CW'(TABLE_SLOTS - 1)) begin
                                    r_status <= ST_FULL;
                                    r_st     <= S_DONE;
                                end else if (i_item.voltage_mv > VOLT_MAX_MV) begin
                                    r_status <= ST_VOLT;
                                    r_st     <= S_DONE;
                                end else begin
                                    r_st <= S_MATCH;
                                end
                            end
                            OP_RESET: begin
                                r_have_prev <= 1'b1;
                                r_st        <= S_CLEAR;
                            end
                            OP_NONE: r_st <= S_DONE;
                        endcase
                    end
                end
                S_CONV: begin
                    // r_rd holds entry r_k-1 when r_rdv is set.
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                        r_k   <= r_k + CW'(1);
                    end else begin
                        if (r_have_prev && r_in.voltage_mv > r_pv
                                && r_in.voltage_mv < w_cv) begin
                            r_den  <= w_cv - r_pv;
                            r_off  <= r_in.voltage_mv - r_pv;
                            r_desc <= w_cl < r_pl;
                            r_num  <= (w_cl >= r_pl) ? w_cl - r_pl : r_pl - w_cl;
                            r_lo   <= r_pl;
                            r_divgo <= 1'b1;
                            r_st   <= S_DIV;
                        end else if (r_in.voltage_mv == w_cv) begin
                            r_held <= w_cl;
                            r_upd  <= 1'b1;
                            r_st   <= S_DONE;
                        end else if (r_k >= r_cnt || r_k >= CW'(TABLE_SLOTS)) begin
                            r_st <= S_DONE;
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                        r_pv        <= w_cv;
                        r_pl        <= w_cl;
                        r_have_prev <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_rsp.done) begin
                        if (!r_desc) begin
                            if ({1'b0, w_q} + (LEVEL_W+VOLT_W+1)'(r_lo)
                                    <= (LEVEL_W+VOLT_W+1)'(LEVEL_MAX)) begin
                                r_held <= r_lo + w_q[LEVEL_W-1:0];
                                r_upd  <= 1'b1;
                                r_st   <= S_DONE;
                            end else begin
                                r_st <= S_CONV;
                            end
                        end else if (w_drop <= (LEVEL_W+VOLT_W+1)'(r_lo)) begin
                            r_held <= r_lo - w_drop[LEVEL_W-1:0];
                            r_upd  <= 1'b1;
                            r_st   <= S_DONE;
                        end else begin
                            r_st <= S_CONV;
                        end
                        // Resume scan: entry r_k-1 is re-read and compared afresh.
                        r_rdv       <= 1'b0;
                        r_k         <= r_k - CW'(1);
                        r_have_prev <= 1'b0;
                    end
                end
                S_MATCH: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                        r_k   <= r_k + CW'(1);
                    end else if (w_cl == r_in.level_in) begin
                        r_pos    <= r_k - CW'(1);
                        r_status <= ST_REPLACED;
                        r_st     <= S_WRITE;
                    end else if (r_k >= r_cnt) begin
                        r_k   <= r_cnt - CW'(1);
                        r_rdv <= 1'b0;
                        r_st  <= S_FIND;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_FIND: begin
                    // Read one entry at a time, top down, waiting for each read.
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!(r_in.voltage_mv < w_cv)) begin
                            r_pos <= r_k + CW'(1);
                            r_k   <= r_cnt;
                            r_st  <= S_SHIFT;
                        end else if (r_k == '0) begin
                            r_status <= ST_NO_SLOT;
                            r_st     <= S_DONE;
                        end else begin
                            r_k <= r_k - CW'(1);
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_k <= r_pos) begin
                        r_st <= S_WRITE;
                    end else if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        r_k   <= r_k - CW'(1);
                    end
                end
                S_WRITE: begin
                    if (r_status != ST_REPLACED) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_k         <= '0;
                    r_rdv       <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_st        <= S_DWAIT;
                end
                S_DWAIT: r_st <= S_ORDER;
                S_ORDER: begin
                    if (!r_rdv) begin
                        r_rdv <= 1'b1;
                        r_k   <= r_k + CW'(1);
                    end else begin
                        if (r_have_prev && w_cl < r_pl) begin
                            r_status <= ST_LVL_ORD;
                            r_st     <= S_DONE;
                        end else if (r_have_prev && w_cv < r_pv) begin
                            r_status <= ST_VOLT_ORD;
                            r_st     <= S_DONE;
                        end else if (r_k >= r_cnt || r_k >= CW'(TABLE_SLOTS)) begin
                            r_st <= S_DONE;
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                        r_pv        <= w_cv;
                        r_pl        <= w_cl;
                        r_have_prev <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign busy                 = (r_st != S_IDLE);
    assign o_valid              = r_ovalid;
    assign o_result.level_out   = r_held;
    assign o_result.updated     = r_upd;
    assign o_result.status      = r_status;
    assign o_result.points_used = 4'(r_cnt);

    ap_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    ap_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted item not taken");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_SLOTS)) else $error("point count overflow");

endmodule
